// ===== hw/rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the LRU sector cache controller: command and
// result transactions, status and register codes, controller/datapath links.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int unsigned CACHE_SLOTS_DEF = 16;
  localparam int unsigned TICK_BITS_DEF   = 32;

  localparam int unsigned CMD_W        = 3;
  localparam int unsigned SECTOR_W     = 28;
  localparam int unsigned TICK_IN_W    = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned SLOT_FIELD_W = 4;
  localparam int unsigned LIMIT_W      = 29;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 29;

  localparam logic [LIMIT_W-1:0] SECTOR_LIMIT_RST = 29'd131072;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP     = 3'd0,
    CMD_FILL       = 3'd1,
    CMD_WRITE      = 3'd2,
    CMD_FLUSH      = 3'd3,
    CMD_INVALIDATE = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SECTOR = 2'd1,
    ST_NOT_READY  = 2'd2,
    ST_READ_ONLY  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECTOR_LIMIT   = 2'd0,
    CFG_DRIVE_READY    = 2'd1,
    CFG_DRIVE_WRITABLE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [SECTOR_W-1:0]  sector;
    logic [TICK_IN_W-1:0] tick_now;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    writeback_valid;
    logic [SECTOR_W-1:0]     writeback_sector;
    logic [SLOT_FIELD_W-1:0] writeback_slot;
    logic                    write_through;
    logic                    last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_first;
    logic scan;
    logic commit;
    logic emit_err;
    logic flush_none;
    logic flush_step;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_flush;
    logic chk_err;
    logic any_wb;
    logic ready;
    logic eval_last;
    logic flush_done;
  } stat_t;

endpackage

// ===== hw/rtl/lsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsc_ctrl
// Sequencer of the sector cache: checks, slot scan, commit and flush walk.
// ----------------------------------------------------------------------------
module lsc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lsc_pkg::stat_t stat_i,
  output lsc_pkg::ctl_t  ctl_o
);
  import lsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_COMMIT,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.is_flush) begin
          if (stat_i.ready && stat_i.any_wb) begin
            ctl_o.rd_en    = 1'b1;
            ctl_o.rd_first = 1'b1;
            state_d        = S_FLUSH;
          end else begin
            ctl_o.flush_none = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (stat_i.chk_err) begin
          ctl_o.emit_err = 1'b1;
          state_d        = S_IDLE;
        end else begin
          ctl_o.rd_en    = 1'b1;
          ctl_o.rd_first = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl_o.scan = 1'b1;
        if (stat_i.eval_last) begin
          state_d = S_COMMIT;
        end else begin
          ctl_o.rd_en = 1'b1;
        end
      end
      S_COMMIT: begin
        ctl_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      S_FLUSH: begin
        ctl_o.flush_step = 1'b1;
        if (stat_i.flush_done) begin
          state_d = S_IDLE;
        end else begin
          ctl_o.rd_en = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.emit_err, ctl_o.flush_none, ctl_o.commit, ctl_o.flush_step}))
    else $error("more than one result source in a cycle");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |-> !busy)
    else $error("command loaded while busy");

endmodule

// ===== hw/rtl/lsc_datapath.sv =====
// ----------------------------------------------------------------------------
// lsc_datapath
// Slot state, tag and stamp memories, scan accumulators and result register.
// ----------------------------------------------------------------------------
module lsc_datapath #(
  parameter int unsigned CACHE_SLOTS = lsc_pkg::CACHE_SLOTS_DEF,
  parameter int unsigned TICK_BITS   = lsc_pkg::TICK_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  lsc_pkg::cmd_t                  cmd_i,
  input  lsc_pkg::ctl_t                  ctl_i,
  output lsc_pkg::stat_t                 stat_o,
  output lsc_pkg::res_t                  res_o,
  output logic                           res_valid_o
);
  import lsc_pkg::*;

  localparam int unsigned SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_SLOTS - 1);

  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+SLOT_FIELD_W-1:0] ext;
    ext = {{SLOT_FIELD_W{1'b0}}, idx};
    return ext[SLOT_FIELD_W-1:0];
  endfunction

  // configuration
  logic [LIMIT_W-1:0] limit_q;
  logic               ready_q;
  logic               writable_q;

  // latched command
  logic [CMD_W-1:0]     cmd_q;
  logic [SECTOR_W-1:0]  tag_q;
  logic [TICK_BITS-1:0] now_q;

  // slot state
  logic [CACHE_SLOTS-1:0] valid_q;
  logic [CACHE_SLOTS-1:0] dirty_q;
  logic [SECTOR_W-1:0]    tag_mem   [CACHE_SLOTS];
  logic [TICK_BITS-1:0]   stamp_mem [CACHE_SLOTS];
  logic [SECTOR_W-1:0]    rd_tag_q;
  logic [TICK_BITS-1:0]   rd_stamp_q;
  logic [SLOT_W-1:0]      eval_idx_q;

  // scan accumulators
  logic                 match_found_q;
  logic [SLOT_W-1:0]    match_idx_q;
  logic                 empty_found_q;
  logic [SLOT_W-1:0]    empty_idx_q;
  logic [SLOT_W-1:0]    min_idx_q;
  logic [TICK_BITS-1:0] min_stamp_q;
  logic [SECTOR_W-1:0]  min_tag_q;

  res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  logic [2*TICK_IN_W-1:0] tick_ext;
  logic [TICK_BITS-1:0]   now_in;
  logic                   is_flush;
  logic                   is_inv;
  logic                   is_lookup;
  logic                   is_alloc;
  status_e                chk_status;
  logic [SLOT_W-1:0]      rd_addr;
  logic                   cur_valid;
  logic                   cur_match;
  logic [CACHE_SLOTS-1:0] wb_mask;
  logic [CACHE_SLOTS-1:0] sel_oh;
  logic                   cur_wb;
  logic                   cur_last;
  logic [SLOT_W-1:0]      sel_idx;
  logic                   victim_dirty;
  logic                   tag_we;
  logic                   stamp_we;
  logic                   alloc_commit;
  logic                   clear_all;

  assign tick_ext  = {{TICK_IN_W{1'b0}}, cmd_i.tick_now};
  assign now_in    = tick_ext[TICK_BITS-1:0];

  assign is_flush  = (cmd_q == CMD_FLUSH) || (cmd_q == CMD_INVALIDATE);
  assign is_inv    = (cmd_q == CMD_INVALIDATE);
  assign is_lookup = (cmd_q == CMD_LOOKUP);
  assign is_alloc  = (cmd_q == CMD_FILL) || (cmd_q == CMD_WRITE);

  always_comb begin
    chk_status = ST_OK;
    if (cmd_q > CMD_INVALIDATE) begin
      chk_status = ST_BAD_SECTOR;
    end else if (!ready_q) begin
      chk_status = ST_NOT_READY;
    end else if ((cmd_q == CMD_WRITE) && !writable_q) begin
      chk_status = ST_READ_ONLY;
    end else if ({1'b0, tag_q} >= limit_q) begin
      chk_status = ST_BAD_SECTOR;
    end
  end

  assign rd_addr   = ctl_i.rd_first ? '0 : eval_idx_q + SLOT_W'(1);
  assign cur_valid = valid_q[eval_idx_q];
  assign cur_match = cur_valid && (rd_tag_q == tag_q);

  // flush walk: earlier entries are already clean, so last means none left
  assign wb_mask  = valid_q & dirty_q;
  assign sel_oh   = CACHE_SLOTS'(1) << eval_idx_q;
  assign cur_wb   = |(wb_mask & sel_oh);
  assign cur_last = ~|(wb_mask & ~sel_oh);

  assign sel_idx      = match_found_q ? match_idx_q :
                        empty_found_q ? empty_idx_q : min_idx_q;
  assign victim_dirty = !match_found_q && !empty_found_q && dirty_q[min_idx_q];
  assign tag_we       = ctl_i.commit && is_alloc;
  assign stamp_we     = ctl_i.commit && (is_alloc || (is_lookup && match_found_q));
  assign alloc_commit = ctl_i.commit && is_alloc;
  assign clear_all    = is_inv && (ctl_i.flush_none || (ctl_i.flush_step && stat_o.flush_done));

  always_comb begin
    stat_o            = '0;
    stat_o.is_flush   = is_flush;
    stat_o.chk_err    = (chk_status != ST_OK);
    stat_o.any_wb     = |wb_mask;
    stat_o.ready      = ready_q;
    stat_o.eval_last  = (eval_idx_q == LAST_SLOT);
    stat_o.flush_done = (cur_wb && cur_last) || (eval_idx_q == LAST_SLOT);
  end

  always_comb begin
    res_d       = '0;
    res_d.last  = 1'b1;
    res_valid_d = 1'b0;
    if (ctl_i.emit_err) begin
      res_valid_d  = 1'b1;
      res_d.status = chk_status;
    end
    if (ctl_i.flush_none) begin
      res_valid_d = 1'b1;
    end
    if (ctl_i.commit) begin
      res_valid_d = 1'b1;
      if (is_lookup) begin
        res_d.hit  = match_found_q;
        res_d.slot = match_found_q ? slot_field(match_idx_q) : '0;
      end else begin
        res_d.slot            = slot_field(sel_idx);
        res_d.write_through   = (cmd_q == CMD_WRITE);
        res_d.writeback_valid = victim_dirty;
        if (victim_dirty) begin
          res_d.writeback_sector = min_tag_q;
          res_d.writeback_slot   = slot_field(min_idx_q);
        end
      end
    end
    if (ctl_i.flush_step && cur_wb) begin
      res_valid_d            = 1'b1;
      res_d.writeback_valid  = 1'b1;
      res_d.writeback_sector = rd_tag_q;
      res_d.writeback_slot   = slot_field(eval_idx_q);
      res_d.last             = cur_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q       <= SECTOR_LIMIT_RST;
      ready_q       <= 1'b0;
      writable_q    <= 1'b0;
      valid_q       <= '0;
      dirty_q       <= '0;
      eval_idx_q    <= '0;
      match_found_q <= 1'b0;
      match_idx_q   <= '0;
      empty_found_q <= 1'b0;
      empty_idx_q   <= '0;
      min_idx_q     <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SECTOR_LIMIT:   limit_q    <= cfg_wdata_i[LIMIT_W-1:0];
          CFG_DRIVE_READY:    ready_q    <= cfg_wdata_i[0];
          CFG_DRIVE_WRITABLE: writable_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      if (ctl_i.rd_en) begin
        eval_idx_q <= rd_addr;
      end
      if (ctl_i.load) begin
        match_found_q <= 1'b0;
        empty_found_q <= 1'b0;
      end
      if (ctl_i.scan) begin
        if (!match_found_q && cur_match) begin
          match_found_q <= 1'b1;
          match_idx_q   <= eval_idx_q;
        end
        if (!empty_found_q && !cur_valid) begin
          empty_found_q <= 1'b1;
          empty_idx_q   <= eval_idx_q;
        end
        // oldest stamp, lowest index kept on a tie
        if ((eval_idx_q == '0) || (rd_stamp_q < min_stamp_q)) begin
          min_idx_q <= eval_idx_q;
        end
      end
      if (clear_all) begin
        valid_q <= '0;
        dirty_q <= '0;
      end else begin
        if (alloc_commit) begin
          valid_q[sel_idx] <= 1'b1;
          dirty_q[sel_idx] <= (cmd_q == CMD_WRITE);
        end
        if (ctl_i.flush_step && cur_wb) begin
          dirty_q[eval_idx_q] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i.cmd;
      tag_q <= cmd_i.sector;
      now_q <= now_in;
    end
    if (ctl_i.scan && ((eval_idx_q == '0) || (rd_stamp_q < min_stamp_q))) begin
      min_stamp_q <= rd_stamp_q;
      min_tag_q   <= rd_tag_q;
    end
    if (res_valid_d) begin
      res_q <= res_d;
    end
  end

  // tag and stamp memories, one read or one write per cycle
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[sel_idx] <= tag_q;
    end
    if (stamp_we) begin
      stamp_mem[sel_idx] <= now_q;
    end
    if (ctl_i.rd_en) begin
      rd_tag_q   <= tag_mem[rd_addr];
      rd_stamp_q <= stamp_mem[rd_addr];
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  a_more_is_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.last |-> res_q.writeback_valid)
    else $error("non-final result without a writeback");

  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.hit |-> (res_q.status == ST_OK) && !res_q.writeback_valid)
    else $error("hit result with error status or writeback");

  a_alloc_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_commit |=> valid_q[$past(sel_idx)])
    else $error("allocated slot not valid");

endmodule

// ===== hw/rtl/lru_sector_cache_controller.sv =====
// ----------------------------------------------------------------------------
// lru_sector_cache_controller
// Tag and replacement controller of a fully associative sector cache with
// oldest-stamp replacement, dirty writeback and flush/invalidate walks.
//
//   port group     direction  transfer condition
//   cfg_*          in         cfg_we_i high at the clock edge
//   start / cmd_i  in         start high and busy low at the clock edge
//   res_o          out        res_valid_o high, taken at the end of that cycle
//
// lookup, fill and write: result strobe after the check state, the slot
// scan and the commit state; the slot scan reads one tag/stamp memory entry
// per cycle. failed checks and a flush with nothing to write: result
// registered from the check state, with no slot scan.
// flush/invalidate: one writeback result per dirty slot, walking the slots
// in index order; busy stays high until the final transaction is shown.
// reset clears valid and dirty bits at once; no clearing pass is needed.
// the receiver cannot stall; results are shown for one cycle only.
// ----------------------------------------------------------------------------
module lru_sector_cache_controller #(
  parameter int unsigned CACHE_SLOTS = lsc_pkg::CACHE_SLOTS_DEF,
  parameter int unsigned TICK_BITS   = lsc_pkg::TICK_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           start,
  input  lsc_pkg::cmd_t                  cmd_i,
  output logic                           busy,
  output logic                           res_valid_o,
  output lsc_pkg::res_t                  res_o
);
  import lsc_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  lsc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  lsc_datapath #(
    .CACHE_SLOTS (CACHE_SLOTS),
    .TICK_BITS   (TICK_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule
